/* hdl/srs_pkg.sv */
// shared types and constants for the sample record statistics block
`default_nettype none

package srs_pkg;

  localparam int EVENT_COUNT = 14;
  localparam int SRC_W       = 5;
  localparam int IDX_W       = 5;
  localparam int READ_W      = 32;
  localparam int RAW_W       = 32;
  localparam int PLEN_W      = 16;
  localparam int WORD_W      = 64;
  localparam int PADDR_W     = 3;

  typedef enum logic [3:0] {
    EV_SKIPPED     = 4'd0,
    EV_FETCH       = 4'd1,
    EV_IC_MISS     = 4'd2,
    EV_FETCH_L1TLB = 4'd3,
    EV_FETCH_L2TLB = 4'd4,
    EV_OP          = 4'd5,
    EV_BRN_RET     = 4'd6,
    EV_BRN_MISP    = 4'd7,
    EV_DC_MISS     = 4'd8,
    EV_DC_L1TLB    = 4'd9,
    EV_DC_L2TLB    = 4'd10,
    EV_REMOTE      = 4'd11,
    EV_DRAM        = 4'd12,
    EV_SRC_OTHER   = 4'd13
  } srs_event_e;

  // record word bit positions
  localparam int FETCH_IC_MISS_BIT = 51;
  localparam int FETCH_L1TLB_BIT   = 55;
  localparam int FETCH_L2TLB_BIT   = 56;
  localparam int BRN_RET_BIT       = 37;
  localparam int BRN_MISP_BIT      = 36;
  localparam int DC_MISS_BIT       = 7;
  localparam int DC_L1TLB_BIT      = 2;
  localparam int DC_L2TLB_BIT      = 3;
  localparam int REMOTE_BIT        = 4;

  localparam logic [SRC_W-1:0] SRC_DRAM = 5'd3;

  // register map
  localparam logic CFG_OP_MODE = 1'b0;

  typedef struct packed {
    logic [EVENT_COUNT-1:0] bump;
    logic                   hist;
    logic [SRC_W-1:0]       src;
  } srs_dec_t;

endpackage

`default_nettype wire

/* hdl/srs_if.sv */
// record and result channel interfaces
`default_nettype none

interface srs_rec_if;
  import srs_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [RAW_W-1:0]    record_size;
  logic [PLEN_W-1:0]   payload_length;
  logic [WORD_W-1:0]   word_zero;
  logic [WORD_W-1:0]   word_two;
  logic [WORD_W-1:0]   word_three;
  logic [WORD_W-1:0]   word_four;
  logic [IDX_W-1:0]    counter_index;

  modport source (output valid, action, record_size, payload_length, word_zero, word_two,
                  word_three, word_four, counter_index, input ready);
  modport sink (input valid, action, record_size, payload_length, word_zero, word_two,
                word_three, word_four, counter_index, output ready);
endinterface

interface srs_res_if;
  import srs_pkg::*;
  logic              valid;
  logic              ready;
  logic [READ_W-1:0] read_data;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, read_data, read_index, input ready);
  modport sink (input valid, read_data, read_index, output ready);
endinterface

`default_nettype wire

/* hdl/sample_record_statistics.sv */
// sample record statistics top level: decode, counters, histogram ram, output queue
// one transaction per cycle in both directions when neither side stalls; counters are updated
// from the stage 1 registers after a record is accepted, and a read result passes through
// the stage 1 registers into the output queue (histogram read-modify-write)
// input stalls only while the two-entry output queue would fill up
// asynchronous reset clears the mode register, event counters and the
// per-bin valid flags, so every histogram bin reads as zero straight away
`default_nettype none

module sample_record_statistics #(
  parameter int COUNT_WIDTH = 32,
  parameter int SOURCE_BINS = 13
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  srs_rec_if.sink                            rec_i,
  srs_res_if.source                          res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import srs_pkg::*;

  localparam int BIN_AW = $clog2(SOURCE_BINS);
  localparam int CW     = COUNT_WIDTH;

  // configuration
  logic op_mode_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_OP_MODE);
  assign prdata = (paddr[2] == CFG_OP_MODE) ? {31'b0, op_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      op_mode_q <= pwdata[0];
    end
  end

  // stage 0: accept and decode, issue histogram read
  srs_dec_t         dec;
  logic             accept;
  logic [5:0]       idx_off;
  logic             hist_rd;
  logic [BIN_AW-1:0] rd_addr;

  srs_decode #(.SOURCE_BINS(SOURCE_BINS)) u_decode (
    .op_mode_i        (op_mode_q),
    .record_size_i    (rec_i.record_size),
    .payload_length_i (rec_i.payload_length),
    .word_zero_i      (rec_i.word_zero),
    .word_two_i       (rec_i.word_two),
    .word_three_i     (rec_i.word_three),
    .word_four_i      (rec_i.word_four),
    .dec_o            (dec)
  );

  assign accept  = rec_i.valid && rec_i.ready;
  assign idx_off = {1'b0, rec_i.counter_index} - 6'd14;
  assign hist_rd = (rec_i.counter_index >= IDX_W'(EVENT_COUNT)) &&
                   (idx_off < 6'(SOURCE_BINS));
  assign rd_addr = rec_i.action ? BIN_AW'(idx_off) : BIN_AW'(dec.src);

  // stage 1 registers
  logic                   s1_valid_q;
  logic                   s1_read_q;
  logic                   s1_hist_rd_q;
  logic                   s1_hist_q;
  logic [EVENT_COUNT-1:0] s1_bump_q;
  logic [BIN_AW-1:0]      s1_addr_q;
  logic [IDX_W-1:0]       s1_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q    <= rec_i.action;
      s1_hist_rd_q <= hist_rd;
      s1_hist_q    <= dec.hist && !rec_i.action;
      s1_bump_q    <= rec_i.action ? '0 : dec.bump;
      s1_addr_q    <= rd_addr;
      s1_idx_q     <= rec_i.counter_index;
    end
  end

  // histogram ram with forwarding of the write made at the read edge
  logic [CW-1:0]          ram_rdata;
  logic [CW-1:0]          bin_val;
  logic [CW-1:0]          bin_inc;
  logic                   hist_we;
  logic                   wr_vld_q;
  logic [BIN_AW-1:0]      wr_addr_q;
  logic [CW-1:0]          wr_data_q;
  logic [SOURCE_BINS-1:0] bin_vld_q;

  srs_ram #(.WIDTH(CW), .DEPTH(SOURCE_BINS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (s1_addr_q),
    .wdata_i (bin_inc),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (wr_vld_q && wr_addr_q == s1_addr_q) begin
      bin_val = wr_data_q;
    end else if (bin_vld_q[s1_addr_q]) begin
      bin_val = ram_rdata;
    end else begin
      bin_val = '0;
    end
  end

  assign bin_inc = bin_val + {{(CW-1){1'b0}}, ~&bin_val};
  assign hist_we = s1_valid_q && s1_hist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q  <= 1'b0;
      bin_vld_q <= '0;
    end else begin
      wr_vld_q <= hist_we;
      if (hist_we) begin
        bin_vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= bin_inc;
    end
  end

  // event counters, each saturating
  logic [CW-1:0] ev_cnt_q [EVENT_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EVENT_COUNT; i++) begin
        ev_cnt_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int i = 0; i < EVENT_COUNT; i++) begin
        if (s1_bump_q[i]) begin
          ev_cnt_q[i] <= ev_cnt_q[i] + {{(CW-1){1'b0}}, ~&ev_cnt_q[i]};
        end
      end
    end
  end

  // read value at stage 1
  logic [CW-1:0] rd_val;

  always_comb begin
    if (s1_idx_q < IDX_W'(EVENT_COUNT)) begin
      rd_val = ev_cnt_q[s1_idx_q[3:0]];
    end else if (s1_hist_rd_q) begin
      rd_val = bin_val;
    end else begin
      rd_val = '0;
    end
  end

  // two-entry output queue
  logic [1:0]        occ_q;
  logic [2:0]        occ_nx;
  logic              push;
  logic              pop;
  logic [READ_W-1:0] head_data_q;
  logic [IDX_W-1:0]  head_idx_q;
  logic [READ_W-1:0] tail_data_q;
  logic [IDX_W-1:0]  tail_idx_q;
  logic [READ_W-1:0] push_data;

  assign push      = s1_valid_q && s1_read_q;
  assign pop       = res_o.valid && res_o.ready;
  assign push_data = READ_W'(rd_val);
  assign occ_nx    = {1'b0, occ_q} + 3'(push) - 3'(pop);
  assign rec_i.ready = occ_nx < 3'd2;

  assign res_o.valid      = (occ_q != 2'd0);
  assign res_o.read_data  = head_data_q;
  assign res_o.read_index = head_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 2'd0;
    end else begin
      occ_q <= occ_nx[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (occ_q == 2'd2) begin
        head_data_q <= tail_data_q;
        head_idx_q  <= tail_idx_q;
        if (push) begin
          tail_data_q <= push_data;
          tail_idx_q  <= s1_idx_q;
        end
      end else if (push) begin
        head_data_q <= push_data;
        head_idx_q  <= s1_idx_q;
      end
    end else if (push) begin
      if (occ_q == 2'd0) begin
        head_data_q <= push_data;
        head_idx_q  <= s1_idx_q;
      end else begin
        tail_data_q <= push_data;
        tail_idx_q  <= s1_idx_q;
      end
    end
  end

`ifndef SYNTH
  // a finishing read never finds the output queue full without a drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (occ_q != 2'd2) || pop)
    else $error("output queue overflow");

  // histogram writes stay inside the bins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> ({1'b0, s1_addr_q} < (BIN_AW + 1)'(SOURCE_BINS)))
    else $error("histogram write out of range");

  // an accepted read transaction reaches stage 1 as a read with no updates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rec_i.action |=> s1_valid_q && s1_read_q && !hist_we && (s1_bump_q == '0))
    else $error("read transaction disturbed counters");

  // forwarded data is only used right after a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> $past(hist_we))
    else $error("stale forwarding");
`endif

endmodule

`default_nettype wire

/* hdl/srs_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module srs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/srs_decode.sv */
// record decode: word count, fetch and op event flags, source bin
`default_nettype none

module srs_decode #(
  parameter int SOURCE_BINS = 13
) (
  input  wire logic                            op_mode_i,
  input  wire logic [srs_pkg::RAW_W-1:0]       record_size_i,
  input  wire logic [srs_pkg::PLEN_W-1:0]      payload_length_i,
  input  wire logic [srs_pkg::WORD_W-1:0]      word_zero_i,
  input  wire logic [srs_pkg::WORD_W-1:0]      word_two_i,
  input  wire logic [srs_pkg::WORD_W-1:0]      word_three_i,
  input  wire logic [srs_pkg::WORD_W-1:0]      word_four_i,
  output srs_pkg::srs_dec_t                    dec_o
);
  import srs_pkg::*;

  logic [RAW_W-1:0]  raw_eff;
  logic              have_words;
  logic [RAW_W-1:0]  nw_raw;
  logic [PLEN_W-1:0] nw_pay;
  logic [2:0]        n_raw;
  logic [2:0]        n_pay;
  logic [2:0]        nwords;
  logic [SRC_W-1:0]  src;
  logic              src_in_range;

  always_comb begin
    raw_eff    = (payload_length_i < PLEN_W'(4)) ? '0 : record_size_i;
    have_words = (raw_eff > RAW_W'(4)) && (payload_length_i > PLEN_W'(8));
    nw_raw     = (raw_eff - RAW_W'(4)) >> 3;
    nw_pay     = (payload_length_i - PLEN_W'(8)) >> 3;
    // only counts up to five matter, so clamp both to 3 bits
    n_raw      = (|nw_raw[RAW_W-1:3]) ? 3'd7 : nw_raw[2:0];
    n_pay      = (|nw_pay[PLEN_W-1:3]) ? 3'd7 : nw_pay[2:0];
    nwords     = (n_raw < n_pay) ? n_raw : n_pay;

    src          = {word_three_i[7:6], word_three_i[2:0]};
    src_in_range = {1'b0, src} < 6'(SOURCE_BINS);

    dec_o      = '0;
    dec_o.src  = src;
    if (!have_words || nwords == 3'd0) begin
      dec_o.bump[EV_SKIPPED] = 1'b1;
    end else if (!op_mode_i) begin
      dec_o.bump[EV_FETCH]       = 1'b1;
      dec_o.bump[EV_IC_MISS]     = word_zero_i[FETCH_IC_MISS_BIT];
      dec_o.bump[EV_FETCH_L1TLB] = word_zero_i[FETCH_L1TLB_BIT];
      dec_o.bump[EV_FETCH_L2TLB] = word_zero_i[FETCH_L2TLB_BIT];
    end else begin
      dec_o.bump[EV_OP] = 1'b1;
      if (nwords > 3'd2 && word_two_i[BRN_RET_BIT]) begin
        dec_o.bump[EV_BRN_RET]  = 1'b1;
        dec_o.bump[EV_BRN_MISP] = word_two_i[BRN_MISP_BIT];
      end
      if (nwords > 3'd4) begin
        dec_o.bump[EV_DC_MISS]  = word_four_i[DC_MISS_BIT];
        dec_o.bump[EV_DC_L1TLB] = word_four_i[DC_L1TLB_BIT];
        dec_o.bump[EV_DC_L2TLB] = word_four_i[DC_L2TLB_BIT];
      end
      if (nwords > 3'd3) begin
        dec_o.bump[EV_REMOTE]    = word_three_i[REMOTE_BIT];
        dec_o.bump[EV_DRAM]      = (src == SRC_DRAM);
        dec_o.hist               = src_in_range;
        dec_o.bump[EV_SRC_OTHER] = !src_in_range;
      end
    end
  end

endmodule

`default_nettype wire

/* sim/sample_record_statistics_tb.sv */
// testbench for sample_record_statistics: directed table, then random records against a predictor
`default_nettype none

module sample_record_statistics_tb;
  import srs_pkg::*;

  localparam int CNT_W     = 32;
  localparam int HIST_BINS = 13;
  localparam int HIST_BASE = EVENT_COUNT;
  localparam int SETTLE    = 8;
  localparam int DRAIN     = 16;
  localparam int PHASE_LEN = 292;
  localparam int IDLE_PCT  = 33;
  localparam int READ_PCT  = 25;
  localparam logic [IDX_W-1:0]   IDX_TOP   = '1;
  localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * CFG_OP_MODE);

  typedef enum logic [1:0] {ROW_MODE, ROW_REC, ROW_READ} row_kind_e;

  typedef struct packed {
    logic              action;
    logic [RAW_W-1:0]  record_size;
    logic [PLEN_W-1:0] plen;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
    logic [WORD_W-1:0] w4;
    logic [IDX_W-1:0]  idx;
  } rec_item_t;

  typedef struct {
    row_kind_e         kind;
    rec_item_t         item;
    bit                fixed;
    logic [READ_W-1:0] fixed_data;
    bit                mode;
  } dir_row_t;

  typedef struct {
    logic [READ_W-1:0] data;
    logic [IDX_W-1:0]  idx;
  } read_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  srs_rec_if rec ();
  srs_res_if res ();

  sample_record_statistics #(
    .COUNT_WIDTH(CNT_W),
    .SOURCE_BINS(HIST_BINS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [CNT_W-1:0] ev_cnt [EVENT_COUNT];
  logic [CNT_W-1:0] hist_cnt [HIST_BINS];
  bit               mode_q;

  read_res_t   pending_reads[$];
  dir_row_t    dir_tab[$];
  int unsigned fail_cnt = 0;
  bit          calm = 1'b0;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  task automatic bump_event(input srs_event_e e);
    ev_cnt[e] = sat_inc(ev_cnt[e]);
  endtask

  task automatic tally_record(input rec_item_t it);
    logic [RAW_W-1:0] raw;
    logic [31:0]      nw, avail;
    logic [SRC_W-1:0] src;
    raw = (it.plen < 4) ? '0 : it.record_size;
    nw  = '0;
    if (raw > 4 && it.plen > 8) begin
      nw    = (raw - 32'd4) >> 3;
      avail = (32'(it.plen) - 32'd8) >> 3;
      if (avail < nw) nw = avail;
    end
    if (nw == 0) begin
      bump_event(EV_SKIPPED);
    end else if (!mode_q) begin
      bump_event(EV_FETCH);
      if (it.w0[FETCH_IC_MISS_BIT]) bump_event(EV_IC_MISS);
      if (it.w0[FETCH_L1TLB_BIT]) bump_event(EV_FETCH_L1TLB);
      if (it.w0[FETCH_L2TLB_BIT]) bump_event(EV_FETCH_L2TLB);
    end else begin
      bump_event(EV_OP);
      if (nw > 2 && it.w2[BRN_RET_BIT]) begin
        bump_event(EV_BRN_RET);
        if (it.w2[BRN_MISP_BIT]) bump_event(EV_BRN_MISP);
      end
      if (nw > 4) begin
        if (it.w4[DC_MISS_BIT]) bump_event(EV_DC_MISS);
        if (it.w4[DC_L1TLB_BIT]) bump_event(EV_DC_L1TLB);
        if (it.w4[DC_L2TLB_BIT]) bump_event(EV_DC_L2TLB);
      end
      if (nw > 3) begin
        // source high bits sit above the remote node bit
        src = {it.w3[7:6], it.w3[2:0]};
        if (it.w3[REMOTE_BIT]) bump_event(EV_REMOTE);
        if (src == SRC_DRAM) bump_event(EV_DRAM);
        if (src < HIST_BINS) hist_cnt[src] = sat_inc(hist_cnt[src]);
        else bump_event(EV_SRC_OTHER);
      end
    end
  endtask

  function automatic logic [READ_W-1:0] counter_value(input logic [IDX_W-1:0] idx);
    logic [CNT_W-1:0] v;
    v = '0;
    if (idx < EVENT_COUNT) v = ev_cnt[idx];
    else if (idx < HIST_BASE + HIST_BINS) v = hist_cnt[idx - HIST_BASE];
    return v[READ_W-1:0];
  endfunction

  function automatic dir_row_t rec_row(input logic [RAW_W-1:0] raw,
                                       input logic [PLEN_W-1:0] plen,
                                       input logic [WORD_W-1:0] w0, w2, w3, w4);
    dir_row_t r;
    r.kind             = ROW_REC;
    r.item             = '0;
    r.item.record_size = raw;
    r.item.plen        = plen;
    r.item.w0          = w0;
    r.item.w2          = w2;
    r.item.w3          = w3;
    r.item.w4          = w4;
    r.item.idx         = IDX_TOP;
    r.fixed            = 1'b0;
    r.fixed_data       = '0;
    r.mode             = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t read_row(input logic [IDX_W-1:0] idx, input bit fixed,
                                        input logic [READ_W-1:0] val);
    dir_row_t r;
    r.kind          = ROW_READ;
    r.item          = '1;
    r.item.action   = 1'b1;
    r.item.idx      = idx;
    r.fixed         = fixed;
    r.fixed_data    = val;
    r.mode          = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t mode_row(input bit m);
    dir_row_t r;
    r.kind       = ROW_MODE;
    r.item       = '0;
    r.fixed      = 1'b0;
    r.fixed_data = '0;
    r.mode       = m;
    return r;
  endfunction

  function automatic rec_item_t rand_item();
    rec_item_t   it;
    int unsigned shape, n;
    it.action = ($urandom_range(99) < READ_PCT);
    it.w0     = {$urandom, $urandom};
    it.w2     = {$urandom, $urandom};
    it.w3     = {$urandom, $urandom};
    it.w4     = {$urandom, $urandom};
    it.idx    = IDX_W'($urandom_range(31));
    shape     = $urandom_range(9);
    if (shape == 0) begin
      it.record_size = $urandom;
      it.plen        = PLEN_W'($urandom);
    end else if (shape == 1) begin
      // sizes around the too-short and truncated-payload boundaries
      it.record_size = $urandom_range(12);
      it.plen        = PLEN_W'($urandom_range(20));
    end else begin
      n              = $urandom_range(1, 7);
      it.record_size = ($urandom_range(7) == 0) ? $urandom : 4 + 8 * n + $urandom_range(7);
      it.plen        = PLEN_W'(8 + 8 * (($urandom_range(3) == 0) ? $urandom_range(7) : n)
                               + $urandom_range(7));
    end
    return it;
  endfunction

  task automatic send_item(input rec_item_t it, input bit fixed,
                           input logic [READ_W-1:0] fixed_val);
    read_res_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      rec.valid <= 1'b0;
      @(negedge clk_i);
    end
    rec.valid          <= 1'b1;
    rec.action         <= it.action;
    rec.record_size    <= it.record_size;
    rec.payload_length <= it.plen;
    rec.word_zero      <= it.w0;
    rec.word_two       <= it.w2;
    rec.word_three     <= it.w3;
    rec.word_four      <= it.w4;
    rec.counter_index  <= it.idx;
    @(posedge clk_i);
    while (!rec.ready) @(posedge clk_i);
    if (it.action) begin
      r.data = fixed ? fixed_val : counter_value(it.idx);
      r.idx  = it.idx;
      pending_reads.push_back(r);
    end else begin
      tally_record(it);
    end
    @(negedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input logic [PADDR_W-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode(input bit m);
    logic [31:0] rd;
    rec.valid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    // records give no result, so let the last ones reach the counters
    repeat (SETTLE) @(negedge clk_i);
    apb_xfer(1'b1, MODE_ADDR, {31'b0, m}, rd);
    apb_xfer(1'b0, MODE_ADDR, '0, rd);
    if (rd !== {31'b0, m}) begin
      fail_cnt++;
      $display("%0t op_mode readback expected %h actual %h", $time, {31'b0, m}, rd);
    end
    mode_q = m;
  endtask

  // result side: random backpressure, check each transaction in order
  always @(negedge clk_i) begin
    res.ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : read_check
    read_res_t exp_r;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_reads.size() == 0) begin
        fail_cnt++;
        $display("%0t unexpected result expected none actual data %h index %0d",
                 $time, res.read_data, res.read_index);
      end else begin
        exp_r = pending_reads.pop_front();
        if (res.read_data !== exp_r.data) begin
          fail_cnt++;
          $display("%0t read_data (index %0d) expected %h actual %h",
                   $time, exp_r.idx, exp_r.data, res.read_data);
        end
        if (res.read_index !== exp_r.idx) begin
          fail_cnt++;
          $display("%0t read_index expected %0d actual %0d",
                   $time, exp_r.idx, res.read_index);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    rec.valid          = 1'b0;
    rec.action         = 1'b0;
    rec.record_size    = '0;
    rec.payload_length = '0;
    rec.word_zero      = '0;
    rec.word_two       = '0;
    rec.word_three     = '0;
    rec.word_four      = '0;
    rec.counter_index  = '0;
    res.ready          = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    mode_q             = 1'b0;
    foreach (ev_cnt[i]) ev_cnt[i] = '0;
    foreach (hist_cnt[i]) hist_cnt[i] = '0;

    // counters straight after reset, and indices with nothing behind them
    dir_tab.push_back(read_row(IDX_W'(EV_SKIPPED), 1'b1, '0));
    dir_tab.push_back(read_row(IDX_W'(HIST_BASE + HIST_BINS - 1), 1'b1, '0));
    dir_tab.push_back(read_row(IDX_TOP, 1'b1, '0));
    // fetch mode: empty and truncated records, real ones, then a zero-word record
    dir_tab.push_back(rec_row('0, '0, '1, '1, '1, '1));
    dir_tab.push_back(rec_row('1, 16'd3, '1, '1, '1, '1));
    dir_tab.push_back(rec_row(32'd12, 16'd16, '1, '1, '1, '1));
    dir_tab.push_back(rec_row('1, '1, '0, '0, '0, '0));
    dir_tab.push_back(rec_row(32'd5, 16'd9, '1, '1, '1, '1));
    dir_tab.push_back(read_row(IDX_W'(EV_SKIPPED), 1'b0, '0));
    dir_tab.push_back(read_row(IDX_W'(EV_FETCH), 1'b0, '0));
    dir_tab.push_back(read_row(IDX_W'(EV_IC_MISS), 1'b0, '0));
    // op mode: one word, branch, source, all bits, full record
    dir_tab.push_back(mode_row(1'b1));
    dir_tab.push_back(rec_row(32'd12, 16'd16, '1, '1, '1, '1));
    dir_tab.push_back(rec_row(32'd28, 16'd40, '0, 64'h0000_0030_0000_0000, '0, '0));
    dir_tab.push_back(rec_row(32'd36, 16'd48, '0, '0, 64'h13, '1));
    dir_tab.push_back(rec_row('1, '1, '1, '1, '1, '1));
    dir_tab.push_back(rec_row(32'd44, 16'd52, '0, '0, 64'h44, 64'h8c));
    dir_tab.push_back(rec_row(32'd44, 16'd52, '0, '0, 64'h45, '0));
    dir_tab.push_back(read_row(IDX_W'(EV_DRAM), 1'b0, '0));
    dir_tab.push_back(read_row(IDX_W'(HIST_BASE + SRC_DRAM), 1'b0, '0));
    dir_tab.push_back(read_row(IDX_W'(HIST_BASE + HIST_BINS - 1), 1'b0, '0));
    dir_tab.push_back(read_row(IDX_W'(EV_SRC_OTHER), 1'b0, '0));
    dir_tab.push_back(read_row(IDX_W'(HIST_BASE + HIST_BINS), 1'b1, '0));
    dir_tab.push_back(mode_row(1'b0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_MODE) set_mode(dir_tab[i].mode);
      else send_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].fixed_data);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph % 2 == 0);
      // one phase runs flat out on both sides
      calm = (ph == 3);
      repeat (PHASE_LEN) send_item(rand_item(), 1'b0, '0);
    end
    calm = 1'b0;
    rec.valid <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
